FILE: hdl/apl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apl_pkg: shared definitions of the all-pole lattice filter
// Widths, codes, sequencer states and fixed-point helpers.
// ----------------------------------------------------------------------------
package apl_pkg;

   localparam int MAX_ORDER = 16;
   localparam int IDX_W     = $clog2(MAX_ORDER);

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int CIDX_W   = 4;
   localparam int ORDER_W  = 5;
   localparam int STATE_W  = 24;
   localparam int PROD_W   = COEF_W + STATE_W;
   localparam int RND_W    = STATE_W + 2;
   localparam int SUM_W    = STATE_W + 3;

   localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;

   localparam int ADDR_W = 3;
   localparam logic REG_ORDER = 1'b0;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_COEF   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_ACC_A,
      ST_MUL_B,
      ST_ACC_B,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                       clip;
      logic signed [STATE_W-1:0]  value;
   } sat_type;

   // q1.15 times q15.8, round half up back to q15.8
   function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] s;
      s = (PROD_W + 1)'(p) + (PROD_W + 1)'(16384);
      return RND_W'(s >>> 15);
   endfunction

   function automatic sat_type sat24(input logic signed [SUM_W-1:0] v);
      sat_type r;
      r.clip  = 1'b0;
      r.value = STATE_W'(v);
      if (v > SUM_W'(24'sh7FFFFF)) begin
         r.clip  = 1'b1;
         r.value = 24'sh7FFFFF;
      end else if (v < SUM_W'(24'sh800000)) begin
         r.clip  = 1'b1;
         r.value = 24'sh800000;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/apl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apl_req_if: input channel of the lattice filter
// Valid/ready beat carrying a sample or a coefficient write.
// ----------------------------------------------------------------------------
interface apl_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [apl_pkg::SAMPLE_W-1:0] sample;
   logic        [apl_pkg::CIDX_W-1:0]   coef_index;
   logic signed [apl_pkg::COEF_W-1:0]   coef_value;
   logic                                restore;
   logic                                snapshot;

   modport source (
      output valid, action, sample, coef_index, coef_value, restore, snapshot,
      input  ready
   );
   modport sink (
      input  valid, action, sample, coef_index, coef_value, restore, snapshot,
      output ready
   );
endinterface
`default_nettype wire

FILE: hdl/apl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apl_rsp_if: result channel of the lattice filter
// Valid/ready beat carrying one filtered sample and its clip flag.
// ----------------------------------------------------------------------------
interface apl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [apl_pkg::SAMPLE_W-1:0] filtered;
   logic                                clipped;

   modport source (
      output valid, filtered, clipped,
      input  ready
   );
   modport sink (
      input  valid, filtered, clipped,
      output ready
   );
endinterface
`default_nettype wire

FILE: hdl/all_pole_lattice_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// all_pole_lattice_filter: fixed-point all-pole lattice iir filter
//
// req channel: a beat with action coef stores one q1.15 reflection
// coefficient in the accept cycle and gives no result. a beat with action
// sample runs the lattice (optionally restoring the backward state from the
// snapshot first, and saving it afterwards) and gives one rsp beat.
// a sample runs stages n - 1 down to 0, n being the order in use (1..16,
// an order of 0 runs as 1, one above 16 as 16); the next beat is accepted
// back in idle, which a coef beat does not leave. all multiplies run on
// one 16x24 multiplier, two dependent multiply-accumulates per stage below
// the top one and one at the top, each a multiply state and an accumulate
// state. req.ready is high only while the sequencer is idle.
// the result sits in an output register; the next beat may be accepted
// while it waits. if rsp stalls until the next sample finishes, the
// sequencer holds that sample in its last state until the register frees.
// csr port: order_in_use at byte address 0, writes take effect at once;
// the user must make them while idle, the block does not enforce it. reset
// clears lattice state, coefficients and snapshot, and sets the order to 10.
// ----------------------------------------------------------------------------
module all_pole_lattice_filter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   apl_req_if.sink                          req,
   apl_rsp_if.source                        rsp,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [apl_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);

   typedef logic signed [apl_pkg::STATE_W-1:0] st_word_type;
   typedef logic signed [apl_pkg::COEF_W-1:0]  coef_word_type;

   apl_pkg::state_type state_ff, state_in;
   logic [apl_pkg::IDX_W-1:0]   stage_ff, stage_in;
   logic [apl_pkg::IDX_W-1:0]   top;
   logic [apl_pkg::ORDER_W-1:0] order_ff, order_in;
   st_word_type   ep_ff, ep_in;
   logic          clip_ff, clip_in;
   logic          snap_ff, snap_in;
   st_word_type   bwd_ff   [apl_pkg::MAX_ORDER];
   st_word_type   bwd_in   [apl_pkg::MAX_ORDER];
   st_word_type   saved_ff [apl_pkg::MAX_ORDER];
   st_word_type   saved_in [apl_pkg::MAX_ORDER];
   coef_word_type coef_ff  [apl_pkg::MAX_ORDER];
   coef_word_type coef_in  [apl_pkg::MAX_ORDER];
   logic signed [apl_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [apl_pkg::RND_W-1:0]  rnd;
   st_word_type   mul_b;
   apl_pkg::sat_type sat_r;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [apl_pkg::SAMPLE_W-1:0] filtered_ff, filtered_in;
   logic                                clipped_ff, clipped_in;
   logic signed [apl_pkg::STATE_W:0]    y_sum;
   logic signed [apl_pkg::STATE_W-8:0]  y_full;
   logic          accept;
   logic          csr_write;

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == apl_pkg::REG_ORDER) ? 32'(order_ff) : 32'd0;

   always_comb begin
      order_in = order_ff;
      if (csr_write && paddr[2] == apl_pkg::REG_ORDER) begin
         order_in = pwdata[apl_pkg::ORDER_W-1:0];
      end
   end

   // highest stage in use
   always_comb begin
      if (order_ff == '0) begin
         top = '0;
      end else if (32'(order_ff) > apl_pkg::MAX_ORDER) begin
         top = apl_pkg::IDX_W'(apl_pkg::MAX_ORDER - 1);
      end else begin
         top = apl_pkg::IDX_W'(order_ff - 5'd1);
      end
   end

   assign req.ready = (state_ff == apl_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;

   // shared multiplier
   assign mul_b   = (state_ff == apl_pkg::ST_MUL_B) ? ep_ff : bwd_ff[stage_ff];
   assign prod_in = apl_pkg::PROD_W'(coef_ff[stage_ff]) * apl_pkg::PROD_W'(mul_b);
   assign rnd     = apl_pkg::round_q15(prod_ff);

   // output rounding
   assign y_sum  = (apl_pkg::STATE_W + 1)'(ep_ff) + (apl_pkg::STATE_W + 1)'(128);
   assign y_full = (apl_pkg::STATE_W - 7)'(y_sum >>> 8);

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      ep_in        = ep_ff;
      clip_in      = clip_ff;
      snap_in      = snap_ff;
      bwd_in       = bwd_ff;
      saved_in     = saved_ff;
      coef_in      = coef_ff;
      filtered_in  = filtered_ff;
      clipped_in   = clipped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      sat_r        = '0;

      case (state_ff)
         apl_pkg::ST_IDLE: begin
            if (accept) begin
               if (req.action == apl_pkg::ACT_COEF) begin
                  if (32'(req.coef_index) < apl_pkg::MAX_ORDER) begin
                     coef_in[apl_pkg::IDX_W'(req.coef_index)] = req.coef_value;
                  end
               end else begin
                  if (req.restore) begin
                     bwd_in = saved_ff;
                  end
                  ep_in    = {req.sample, 8'd0};
                  clip_in  = 1'b0;
                  snap_in  = req.snapshot;
                  stage_in = top;
                  state_in = apl_pkg::ST_MUL_A;
               end
            end
         end
         apl_pkg::ST_MUL_A: begin
            state_in = apl_pkg::ST_ACC_A;
         end
         apl_pkg::ST_ACC_A: begin
            sat_r   = apl_pkg::sat24(apl_pkg::SUM_W'(ep_ff) - apl_pkg::SUM_W'(rnd));
            ep_in   = sat_r.value;
            clip_in = clip_ff | sat_r.clip;
            if (stage_ff != top) begin
               state_in = apl_pkg::ST_MUL_B;
            end else if (stage_ff == '0) begin
               state_in = apl_pkg::ST_DONE;
            end else begin
               stage_in = stage_ff - 1'b1;
               state_in = apl_pkg::ST_MUL_A;
            end
         end
         apl_pkg::ST_MUL_B: begin
            state_in = apl_pkg::ST_ACC_B;
         end
         apl_pkg::ST_ACC_B: begin
            sat_r   = apl_pkg::sat24(apl_pkg::SUM_W'(bwd_ff[stage_ff]) + apl_pkg::SUM_W'(rnd));
            bwd_in[stage_ff + 1'b1] = sat_r.value;
            clip_in = clip_ff | sat_r.clip;
            if (stage_ff == '0) begin
               state_in = apl_pkg::ST_DONE;
            end else begin
               stage_in = stage_ff - 1'b1;
               state_in = apl_pkg::ST_MUL_A;
            end
         end
         apl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               bwd_in[0] = ep_ff;
               if (snap_ff) begin
                  saved_in = bwd_in;
               end
               rsp_valid_in = 1'b1;
               if (y_full > 17'sd32767) begin
                  filtered_in = 16'sh7FFF;
                  clipped_in  = 1'b1;
               end else if (y_full < -17'sd32768) begin
                  filtered_in = 16'sh8000;
                  clipped_in  = 1'b1;
               end else begin
                  filtered_in = apl_pkg::SAMPLE_W'(y_full);
                  clipped_in  = clip_ff;
               end
               state_in = apl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apl_pkg::ST_IDLE;
         stage_ff     <= '0;
         order_ff     <= apl_pkg::ORDER_RESET;
         ep_ff        <= '0;
         clip_ff      <= 1'b0;
         snap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < apl_pkg::MAX_ORDER; k++) begin
            bwd_ff[k]   <= '0;
            saved_ff[k] <= '0;
            coef_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         order_ff     <= order_in;
         ep_ff        <= ep_in;
         clip_ff      <= clip_in;
         snap_ff      <= snap_in;
         rsp_valid_ff <= rsp_valid_in;
         bwd_ff       <= bwd_in;
         saved_ff     <= saved_in;
         coef_ff      <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      filtered_ff <= filtered_in;
      clipped_ff  <= clipped_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.filtered = filtered_ff;
   assign rsp.clipped  = clipped_ff;

   // checks
   a_coef_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == apl_pkg::ACT_COEF) |=> state_ff == apl_pkg::ST_IDLE)
      else $error("coefficient beat started the sequencer");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == apl_pkg::ACT_SAMPLE) |=>
         (state_ff == apl_pkg::ST_MUL_A && stage_ff == top))
      else $error("sample beat did not start at the top stage");

   a_stage_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != apl_pkg::ST_IDLE) |-> stage_ff <= top)
      else $error("stage counter beyond order in use");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == apl_pkg::ST_DONE && state_in == apl_pkg::ST_IDLE) |=> rsp_valid_ff)
      else $error("finished sample gave no result beat");

endmodule
`default_nettype wire

FILE: verif/apl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_checker: scoreboard of the all-pole lattice filter
// Watches the req, rsp and csr ports and keeps a private copy of the lattice
// state, the coefficients and the order. Each accepted sample beat is run
// through that copy. Each rsp beat is compared, field by field, with the
// oldest expected output. Mismatches and the number of outputs still due
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module apl_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   apl_req_if                               req_mon,
   apl_rsp_if                               rsp_mon,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic                        pready,
   input  wire logic [apl_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output int                               mismatches,
   output int                               results_due
);

   localparam longint BWD_MAX = 64'sd8388607;
   localparam longint BWD_MIN = -64'sd8388608;

   typedef struct packed {
      logic signed [apl_pkg::SAMPLE_W-1:0] filtered;
      logic                                clipped;
   } filt_result_type;

   filt_result_type expected_outputs[$];

   logic signed [apl_pkg::STATE_W-1:0] lat_bwd   [apl_pkg::MAX_ORDER];
   logic signed [apl_pkg::STATE_W-1:0] lat_saved [apl_pkg::MAX_ORDER];
   logic signed [apl_pkg::COEF_W-1:0]  lat_coef  [apl_pkg::MAX_ORDER];
   logic        [apl_pkg::ORDER_W-1:0] lat_order;
   bit                                 lat_clip;

   // q1.15 times q15.8, round half up
   function automatic longint round_prod(input longint coef, input longint val);
      return (coef * val + 64'sd16384) >>> 15;
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > BWD_MAX) begin
         lat_clip = 1'b1;
         return BWD_MAX;
      end
      if (v < BWD_MIN) begin
         lat_clip = 1'b1;
         return BWD_MIN;
      end
      return v;
   endfunction

   function automatic filt_result_type run_lattice(
      input logic signed [apl_pkg::SAMPLE_W-1:0] smp,
      input logic rst, input logic snap);
      int              n;
      longint          fwd;
      longint          y;
      filt_result_type r;
      n = int'(lat_order);
      lat_clip = 1'b0;
      if (n < 1) n = 1;
      if (n > apl_pkg::MAX_ORDER) n = apl_pkg::MAX_ORDER;
      if (rst) lat_bwd = lat_saved;
      fwd = clamp24(longint'(smp) * 256 - round_prod(lat_coef[n-1], lat_bwd[n-1]));
      for (int i = n - 2; i >= 0; i--) begin
         fwd = clamp24(fwd - round_prod(lat_coef[i], lat_bwd[i]));
         lat_bwd[i+1] = apl_pkg::STATE_W'(clamp24(longint'(lat_bwd[i])
                                                  + round_prod(lat_coef[i], fwd)));
      end
      lat_bwd[0] = apl_pkg::STATE_W'(fwd);
      if (snap) lat_saved = lat_bwd;
      y = (fwd + 128) >>> 8;
      if (y > 32767) begin
         y = 32767;
         lat_clip = 1'b1;
      end
      if (y < -32768) begin
         y = -32768;
         lat_clip = 1'b1;
      end
      r.filtered = apl_pkg::SAMPLE_W'(y);
      r.clipped  = lat_clip;
      return r;
   endfunction

   always @(posedge clock) begin
      filt_result_type want;
      if (reset) begin
         for (int i = 0; i < apl_pkg::MAX_ORDER; i++) begin
            lat_bwd[i]   = '0;
            lat_saved[i] = '0;
            lat_coef[i]  = '0;
         end
         lat_order = apl_pkg::ORDER_RESET;
         expected_outputs.delete();
         mismatches  = 0;
         results_due = 0;
      end else begin
         if (psel && penable && pwrite && pready
             && paddr == apl_pkg::ADDR_W'(4 * int'(apl_pkg::REG_ORDER)))
            lat_order = pwdata[apl_pkg::ORDER_W-1:0];
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == apl_pkg::ACT_COEF) begin
               if (int'(req_mon.coef_index) < apl_pkg::MAX_ORDER)
                  lat_coef[req_mon.coef_index] = req_mon.coef_value;
            end else begin
               expected_outputs.push_back(run_lattice(req_mon.sample, req_mon.restore,
                                                      req_mon.snapshot));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected rsp beat: filtered %0d clipped %0b",
                      rsp_mon.filtered, rsp_mon.clipped);
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_mon.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d", want.filtered, rsp_mon.filtered);
                  mismatches++;
               end
               if (rsp_mon.clipped !== want.clipped) begin
                  $error("clipped: expected %0b, actual %0b", want.clipped, rsp_mon.clipped);
                  mismatches++;
               end
            end
         end
         results_due = expected_outputs.size();
      end
   end

endmodule

FILE: verif/tb_all_pole_lattice_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_all_pole_lattice_filter: testbench of the all-pole lattice filter
// Drives coefficient and sample beats, first a directed set of extremes,
// snapshot and restore cases, then random traffic over several filter
// orders, including out-of-range ones. The sender and the receiver idle at
// random in three mixes, and one long receiver hold-off backs up the block.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_all_pole_lattice_filter;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 216;
   localparam int NUM_PHASES   = 9;
   localparam int STALL_CYCLES = 500;

   typedef struct {
      logic                                action;
      logic signed [apl_pkg::SAMPLE_W-1:0] sample;
      logic        [apl_pkg::CIDX_W-1:0]   coef_index;
      logic signed [apl_pkg::COEF_W-1:0]   coef_value;
      logic                                restore;
      logic                                snapshot;
   } beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [apl_pkg::ADDR_W-1:0] paddr;
   logic [31:0]                pwdata;
   logic [31:0]                prdata;
   logic                       pready;

   int mismatches;
   int results_due;
   int src_idle_pct;
   int snk_idle_pct;
   int cycle_count = 0;
   bit hold_go = 1'b0;

   apl_req_if req_if ();
   apl_rsp_if rsp_if ();

   all_pole_lattice_filter DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   apl_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_left = STALL_CYCLES;
            hold_go   = 1'b0;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_beat(input beat_type b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= b.action;
      req_if.sample     <= b.sample;
      req_if.coef_index <= b.coef_index;
      req_if.coef_value <= b.coef_value;
      req_if.restore    <= b.restore;
      req_if.snapshot   <= b.snapshot;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   function automatic beat_type sample_beat(input logic signed [apl_pkg::SAMPLE_W-1:0] smp,
                                            input logic rst, input logic snap);
      beat_type b;
      b.action     = apl_pkg::ACT_SAMPLE;
      b.sample     = smp;
      b.coef_index = apl_pkg::CIDX_W'($urandom());
      b.coef_value = apl_pkg::COEF_W'($urandom());
      b.restore    = rst;
      b.snapshot   = snap;
      return b;
   endfunction

   function automatic beat_type coef_beat(input logic [apl_pkg::CIDX_W-1:0] idx,
                                          input logic signed [apl_pkg::COEF_W-1:0] val);
      beat_type b;
      b.action     = apl_pkg::ACT_COEF;
      b.sample     = apl_pkg::SAMPLE_W'($urandom());
      b.coef_index = idx;
      b.coef_value = val;
      b.restore    = 1'(($urandom()));
      b.snapshot   = 1'(($urandom()));
      return b;
   endfunction

   task automatic random_beat();
      beat_type b;
      int       pick;
      int       shape;
      shape = $urandom_range(99);
      if ($urandom_range(99) < 15) begin
         if (shape < 70)
            pick = $urandom_range(24000) - 12000;
         else if (shape < 85)
            pick = ($urandom_range(1) == 1) ? 32767 : -32768;
         else
            pick = $urandom();
         b = coef_beat(apl_pkg::CIDX_W'($urandom()), apl_pkg::COEF_W'(pick));
      end else begin
         if (shape < 10)
            pick = ($urandom_range(1) == 1) ? 32767 : -32768;
         else if (shape < 50)
            pick = $urandom_range(4000) - 2000;
         else
            pick = $urandom();
         b = sample_beat(apl_pkg::SAMPLE_W'(pick), $urandom_range(9) == 0,
                         $urandom_range(9) == 0);
      end
      send_beat(b);
   endtask

   task automatic csr_write(input logic [31:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= apl_pkg::ADDR_W'(4 * int'(apl_pkg::REG_ORDER));
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // wait for every result, then let the sequencer run out
   task automatic settle();
      req_if.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase_order [NUM_PHASES];
      logic [31:0] order_word;
      phase_order = '{16, 0, 1, 31, 17, 4, -1, 8, -1};
      req_if.valid      <= 1'b0;
      req_if.action     <= apl_pkg::ACT_SAMPLE;
      req_if.sample     <= '0;
      req_if.coef_index <= '0;
      req_if.coef_value <= '0;
      req_if.restore    <= 1'b0;
      req_if.snapshot   <= 1'b0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      src_idle_pct = 13;
      snk_idle_pct = 48;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset order of 10
      send_beat(sample_beat(16'sd1000, 1'b0, 1'b0));
      send_beat(coef_beat(4'd0, 16'sd16384));
      send_beat(coef_beat(4'd9, -16'sd32768));
      send_beat(coef_beat(4'd15, 16'sd32767));
      send_beat(sample_beat(16'sd32767, 1'b0, 1'b0));
      send_beat(sample_beat(-16'sd32768, 1'b0, 1'b1));
      send_beat(sample_beat(16'sd0, 1'b0, 1'b0));
      send_beat(sample_beat(16'sd12345, 1'b1, 1'b0));
      send_beat(sample_beat(-16'sd1, 1'b1, 1'b1));
      send_beat(coef_beat(4'd1, 16'sd32767));
      send_beat(coef_beat(4'd2, -16'sd32768));
      send_beat(coef_beat(4'd5, 16'sd30000));
      repeat (3) send_beat(sample_beat(16'sd32767, 1'b0, 1'b0));
      repeat (2) send_beat(sample_beat(-16'sd32768, 1'b0, 1'b0));
      send_beat(sample_beat(16'sd0, 1'b1, 1'b0));
      send_beat(sample_beat(16'sd7, 1'b0, 1'b1));
      send_beat(coef_beat(4'd0, -16'sd1));
      send_beat(sample_beat(-16'sd7, 1'b1, 1'b0));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         if (ph < 3) begin
            src_idle_pct = 13;
            snk_idle_pct = 48;
         end else if (ph < 6) begin
            src_idle_pct = 48;
            snk_idle_pct = 13;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         if (phase_order[ph] < 0)
            order_word = {27'($urandom()), 5'($urandom_range(31))};
         else
            order_word = 32'(phase_order[ph]);
         csr_write(order_word);
         if (ph == 6) hold_go = 1'b1;
         repeat (PHASE_ITEMS) random_beat();
      end

      settle();
      if (mismatches == 0 && results_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
